>>> design/ica_pkg.sv
// package for the integer calculator alu: opcodes, payload structs, fsm states
// and controller to datapath command/status structs
// no dependencies
package ica_pkg;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned CmdWidth  = 3;

  typedef enum logic [CmdWidth-1:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MAX = 3'd2,
    OP_DIV = 3'd3,
    OP_REM = 3'd4,
    OP_POW = 3'd5,
    OP_PCT = 3'd6,
    OP_MUL = 3'd7
  } op_e;

  typedef struct packed {
    logic [CmdWidth-1:0]         cmd;
    logic signed [DataWidth-1:0] operand_a;
    logic signed [DataWidth-1:0] operand_b;
  } req_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] result_value;
    logic                        divide_by_zero;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_PCT,
    ST_ITER,
    ST_FIX,
    ST_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture operands
    logic mul;       // product of operands into x
    logic pct_setup; // take |x| as dividend, 100 as divisor
    logic step;      // one iteration of divider or power
    logic fix;       // sign/select final result
    logic emit;      // drive result strobe
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic iter_last;
  } stat_t;

endpackage

>>> design/ica_ctrl.sv
// controller fsm for the integer calculator alu
// depends on ica_pkg
module ica_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [2:0]         cmd_i,
  input  ica_pkg::stat_t     stat_i,
  output ica_pkg::ctrl_t     ctrl_o,
  output logic               busy_o
);

  ica_pkg::state_e state_q, state_d;
  logic [2:0]      cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ica_pkg::ST_IDLE;
      cmd_q   <= ica_pkg::OP_ADD;
    end else begin
      state_q <= state_d;
      if (start_i && state_q == ica_pkg::ST_IDLE) cmd_q <= cmd_i;
    end
  end

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    busy_o  = (state_q != ica_pkg::ST_IDLE);
    unique case (state_q)
      ica_pkg::ST_IDLE: begin
        if (start_i) begin
          ctrl_o.load = 1'b1;
          state_d     = ica_pkg::ST_MUL;
        end
      end
      ica_pkg::ST_MUL: begin
        case (cmd_q) inside
          ica_pkg::OP_PCT, ica_pkg::OP_MUL: begin
            ctrl_o.mul = 1'b1;
            state_d = (cmd_q == ica_pkg::OP_PCT) ? ica_pkg::ST_PCT : ica_pkg::ST_FIX;
          end
          ica_pkg::OP_DIV, ica_pkg::OP_REM, ica_pkg::OP_POW: state_d = ica_pkg::ST_ITER;
          default: state_d = ica_pkg::ST_FIX;
        endcase
      end
      ica_pkg::ST_PCT: begin
        ctrl_o.pct_setup = 1'b1;
        state_d          = ica_pkg::ST_ITER;
      end
      ica_pkg::ST_ITER: begin
        ctrl_o.step = 1'b1;
        if (stat_i.iter_last) state_d = ica_pkg::ST_FIX;
      end
      ica_pkg::ST_FIX: begin
        ctrl_o.fix = 1'b1;
        state_d    = ica_pkg::ST_DONE;
      end
      ica_pkg::ST_DONE: begin
        ctrl_o.emit = 1'b1;
        state_d     = ica_pkg::ST_IDLE;
      end
      default: state_d = ica_pkg::ST_IDLE;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ica_pkg::ST_DONE) |=> (state_q == ica_pkg::ST_IDLE))
    else $error("done not followed by idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted transfer did not raise busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(ctrl_o))
    else $error("more than one datapath command");

endmodule

>>> design/ica_dp.sv
// datapath for the integer calculator alu: operand registers, multipliers,
// restoring divider and square-and-multiply power; depends on ica_pkg
module ica_dp #(
  parameter int unsigned DATA_WIDTH = ica_pkg::DataWidth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ica_pkg::ctrl_t               ctrl_i,
  input  logic [2:0]                   cmd_i,
  input  logic signed [DATA_WIDTH-1:0] operand_a_i,
  input  logic signed [DATA_WIDTH-1:0] operand_b_i,
  output ica_pkg::stat_t               stat_o,
  output logic                         valid_o,
  output logic signed [DATA_WIDTH-1:0] result_value_o,
  output logic                         divide_by_zero_o
);

  localparam int unsigned CntW = $clog2(DATA_WIDTH);
  localparam logic [DATA_WIDTH-1:0] Hundred = DATA_WIDTH'(100);
  localparam logic [DATA_WIDTH-1:0] One     = DATA_WIDTH'(1);

  logic [2:0]            cmd_q;
  logic [DATA_WIDTH-1:0] a_q, b_q;
  logic [DATA_WIDTH-1:0] x_q;   // dividend shift / power base
  logic [DATA_WIDTH-1:0] y_q;   // divisor magnitude / exponent
  logic [DATA_WIDTH-1:0] r_q;   // partial remainder / power accumulator
  logic [DATA_WIDTH-1:0] q_q;   // quotient
  logic                  nn_q, nd_q;
  logic [CntW-1:0]       cnt_q;
  logic                  valid_q;
  logic [DATA_WIDTH-1:0] res_q;
  logic                  dz_q;

  logic [DATA_WIDTH-1:0] abs_a, abs_b, abs_x;
  logic [DATA_WIDTH:0]   rs, diff;
  logic                  is_pow;
  logic [DATA_WIDTH-1:0] mul_ab, mul_rx, mul_xx;
  logic [DATA_WIDTH-1:0] fin;
  logic                  dz;

  assign abs_a  = a_q[DATA_WIDTH-1] ? (~a_q + One) : a_q;
  assign abs_b  = b_q[DATA_WIDTH-1] ? (~b_q + One) : b_q;
  assign abs_x  = x_q[DATA_WIDTH-1] ? (~x_q + One) : x_q;
  assign is_pow = (cmd_q == ica_pkg::OP_POW);
  assign rs     = {r_q, x_q[DATA_WIDTH-1]};
  assign diff   = rs - {1'b0, y_q};
  assign mul_ab = a_q * b_q;
  assign mul_rx = r_q * x_q;
  assign mul_xx = x_q * x_q;
  assign stat_o.iter_last = (cnt_q == CntW'(DATA_WIDTH-1));
  assign dz = (b_q == '0) &&
              (cmd_q == ica_pkg::OP_DIV || cmd_q == ica_pkg::OP_REM);

  always_comb begin
    case (cmd_q) inside
      ica_pkg::OP_ADD: fin = a_q + b_q;
      ica_pkg::OP_SUB: fin = a_q - b_q;
      ica_pkg::OP_MAX: fin = ($signed(a_q) > $signed(b_q)) ? a_q : b_q;
      ica_pkg::OP_DIV, ica_pkg::OP_PCT: fin = (nn_q != nd_q) ? (~q_q + One) : q_q;
      ica_pkg::OP_REM: fin = nn_q ? (~r_q + One) : r_q;
      ica_pkg::OP_POW: fin = (b_q[DATA_WIDTH-1] || b_q == '0) ? One : r_q;
      default:         fin = x_q;
    endcase
    if (dz) fin = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      valid_q <= ctrl_i.emit;
      if (ctrl_i.step) cnt_q <= cnt_q + CntW'(1);
      else             cnt_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q <= cmd_i;
      a_q   <= operand_a_i;
      b_q   <= operand_b_i;
    end else if (ctrl_i.mul) begin
      x_q <= mul_ab;
    end else if (ctrl_i.pct_setup) begin
      x_q  <= abs_x;
      nn_q <= x_q[DATA_WIDTH-1];
      nd_q <= 1'b0;
      y_q  <= Hundred;
      r_q  <= '0;
      q_q  <= '0;
    end else if (ctrl_i.step) begin
      if (is_pow) begin
        if (y_q[0]) r_q <= mul_rx;
        x_q <= mul_xx;
        y_q <= y_q >> 1;
      end else begin
        x_q <= x_q << 1;
        if (!diff[DATA_WIDTH]) begin
          r_q <= diff[DATA_WIDTH-1:0];
          q_q <= {q_q[DATA_WIDTH-2:0], 1'b1};
        end else begin
          r_q <= rs[DATA_WIDTH-1:0];
          q_q <= {q_q[DATA_WIDTH-2:0], 1'b0};
        end
      end
    end else if (ctrl_i.fix) begin
      res_q <= fin;
      dz_q  <= dz;
    end else if (!ctrl_i.emit && cmd_q != ica_pkg::OP_PCT) begin
      // setup cycle before iterating divide or power
      r_q  <= is_pow ? One : '0;
      q_q  <= '0;
      x_q  <= is_pow ? a_q : abs_a;
      y_q  <= is_pow ? b_q : abs_b;
      nn_q <= a_q[DATA_WIDTH-1];
      nd_q <= b_q[DATA_WIDTH-1];
    end
  end

  assign valid_o          = valid_q;
  assign result_value_o   = res_q;
  assign divide_by_zero_o = dz_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |=> !valid_q)
    else $error("result strobe longer than one cycle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && dz_q) |-> (res_q == '0))
    else $error("divide by zero with nonzero result");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.step |=> (cnt_q != '0) || $past(stat_o.iter_last))
    else $error("iteration count lost");

endmodule

>>> design/integer_calc_alu.sv
// top level of the integer calculator alu: controller and datapath
// depends on ica_pkg, ica_ctrl, ica_dp
//
// One operation at a time. A transfer is taken when start is high and busy
// low; the result appears on result_o for one cycle with valid_o high and
// cannot be stalled. Add, sub, max and mul pass through the mul, fix and
// done states; div, rem and pow run one bit per cycle through the shared
// shift and subtract / square-and-multiply loop; percent does a multiply,
// then a divide by 100 through the same loop.
module integer_calc_alu (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  ica_pkg::req_t req_i,
  output logic          busy,
  output logic          valid_o,
  output ica_pkg::rsp_t result_o
);

  ica_pkg::ctrl_t ctrl;
  ica_pkg::stat_t stat;
  logic signed [ica_pkg::DataWidth-1:0] res;
  logic                                 dz;

  ica_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .cmd_i  (req_i.cmd),
    .stat_i (stat),
    .ctrl_o (ctrl),
    .busy_o (busy)
  );

  ica_dp #(.DATA_WIDTH(ica_pkg::DataWidth)) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .cmd_i           (req_i.cmd),
    .operand_a_i     (req_i.operand_a),
    .operand_b_i     (req_i.operand_b),
    .stat_o          (stat),
    .valid_o         (valid_o),
    .result_value_o  (res),
    .divide_by_zero_o(dz)
  );

  assign result_o.result_value   = res;
  assign result_o.divide_by_zero = dz;

endmodule

>>> test/integer_calc_alu_test.sv
// testbench for the integer calculator alu: directed and random operations
// checked against a behavioural predictor through a small scoreboard class
// depends on ica_pkg and integer_calc_alu
module integer_calc_alu_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TimeoutCycles = 400000;

  function automatic ica_pkg::rsp_t calc_result(ica_pkg::req_t rq);
    ica_pkg::rsp_t r;
    logic signed [31:0] a, b, base, acc;
    logic [31:0] e;
    r.result_value = '0;
    r.divide_by_zero = 1'b0;
    a = rq.operand_a;
    b = rq.operand_b;
    case (ica_pkg::op_e'(rq.cmd))
      ica_pkg::OP_ADD: r.result_value = a + b;
      ica_pkg::OP_SUB: r.result_value = a - b;
      ica_pkg::OP_MAX: r.result_value = (a > b) ? a : b;
      ica_pkg::OP_DIV: begin
        if (b == 0) r.divide_by_zero = 1'b1;
        else if (a == 32'sh80000000 && b == -32'sd1) r.result_value = a;
        else r.result_value = a / b;
      end
      ica_pkg::OP_REM: begin
        if (b == 0) r.divide_by_zero = 1'b1;
        else if (b == -32'sd1) r.result_value = '0;
        else r.result_value = a % b;
      end
      ica_pkg::OP_POW: begin
        acc = 32'sd1;
        if (b > 0) begin
          base = a;
          e = b;
          while (e != 0) begin
            if (e[0]) acc = acc * base;
            base = base * base;
            e = e >> 1;
          end
        end
        r.result_value = acc;
      end
      ica_pkg::OP_PCT: begin
        acc = a * b;
        r.result_value = acc / 32'sd100;
      end
      default: r.result_value = a * b;
    endcase
    return r;
  endfunction

  class alu_scoreboard;
    ica_pkg::rsp_t pending_q[$];
    int errors;

    function void note_transfer(ica_pkg::req_t rq);
      pending_q.push_back(calc_result(rq));
    endfunction

    function void check_result(ica_pkg::rsp_t got);
      ica_pkg::rsp_t want;
      if (pending_q.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %h", $realtime, got);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (got.result_value !== want.result_value) begin
        $display("%0t result_value: expected %h, actual %h", $realtime,
                 want.result_value, got.result_value);
        errors++;
      end
      if (got.divide_by_zero !== want.divide_by_zero) begin
        $display("%0t divide_by_zero: expected %b, actual %b", $realtime,
                 want.divide_by_zero, got.divide_by_zero);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  ica_pkg::req_t req_i = '0;
  logic busy, valid_o;
  ica_pkg::rsp_t result_o;
  alu_scoreboard sb = new();
  int unsigned cycles = 0;

  integer_calc_alu dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .req_i(req_i),
    .busy(busy), .valid_o(valid_o), .result_o(result_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (rst_ni && valid_o) sb.check_result(result_o);
    if (cycles > TimeoutCycles) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_op(ica_pkg::op_e op, logic [31:0] a, logic [31:0] b);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    req_i <= '{cmd: op, operand_a: a, operand_b: b};
    do @(posedge clk_i); while (busy);
    sb.note_transfer('{cmd: op, operand_a: a, operand_b: b});
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 12) - 6;
      1: return {$urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff} ^ $urandom_range(0, 3);
      2: return $urandom_range(0, 200) - 100;
      default: return $urandom;
    endcase
  endfunction

  task automatic wait_drained();
    start <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
  endtask

  initial begin
    logic [31:0] a, b;
    ica_pkg::op_e op;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    send_op(ica_pkg::OP_ADD, 32'h7fff_ffff, 32'd1);
    send_op(ica_pkg::OP_SUB, 32'h8000_0000, 32'd1);
    send_op(ica_pkg::OP_MAX, 32'h8000_0000, 32'h7fff_ffff);
    send_op(ica_pkg::OP_MAX, 32'hffff_fffb, 32'hffff_fffb);
    send_op(ica_pkg::OP_DIV, 32'd7, 32'd0);
    send_op(ica_pkg::OP_REM, 32'hffff_fff9, 32'd0);
    send_op(ica_pkg::OP_DIV, 32'h8000_0000, 32'hffff_ffff);
    send_op(ica_pkg::OP_REM, 32'h8000_0000, 32'hffff_ffff);
    send_op(ica_pkg::OP_DIV, 32'hffff_fff9, 32'd2);
    send_op(ica_pkg::OP_REM, 32'hffff_fff9, 32'd2);
    send_op(ica_pkg::OP_REM, 32'd7, 32'hffff_fffe);
    send_op(ica_pkg::OP_POW, 32'd3, 32'd0);
    send_op(ica_pkg::OP_POW, 32'd3, 32'h8000_0000);
    send_op(ica_pkg::OP_POW, 32'hffff_fffd, 32'd5);
    send_op(ica_pkg::OP_POW, 32'd2, 32'd31);
    send_op(ica_pkg::OP_POW, 32'h7fff_ffff, 32'h7fff_ffff);
    send_op(ica_pkg::OP_PCT, 32'hffff_ff9c, 32'd3);
    send_op(ica_pkg::OP_PCT, 32'h7fff_ffff, 32'h7fff_ffff);
    send_op(ica_pkg::OP_MUL, 32'h8000_0000, 32'hffff_ffff);
    send_op(ica_pkg::OP_MUL, 32'hffff_ffff, 32'hffff_ffff);
    send_op(ica_pkg::OP_ADD, 32'd0, 32'd0);
    wait_drained();
    for (int i = 0; i < 1750; i++) begin
      op = ica_pkg::op_e'($urandom_range(0, 7));
      a = rand_operand();
      b = rand_operand();
      send_op(op, a, b);
      if (i == 800) wait_drained();
    end
    wait_drained();
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
